// ===== hdl/mlt_pkg.sv =====
`timescale 1ns / 1ps

package mlt_pkg;

  // Table geometry
  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Field widths
  localparam int OPC_W   = 2;
  localparam int MAC_W   = 48;
  localparam int VLAN_W  = 12;
  localparam int PORT_W  = 4;
  localparam int STAMP_W = 32;
  localparam int SLOT_W  = 6;

  // Stream data widths
  localparam int IN_FIELD_W  = MAC_W + VLAN_W + PORT_W + STAMP_W;
  localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 1 + PORT_W + SLOT_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // Request queue, depth is a power of two so pointers wrap by themselves
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Opcodes on in_tuser
  localparam logic [OPC_W-1:0] OPC_LEARN  = 2'd0;
  localparam logic [OPC_W-1:0] OPC_LOOKUP = 2'd1;
  localparam logic [OPC_W-1:0] OPC_FLUSH  = 2'd2;

  typedef enum logic [1:0] {
    OP_LEARN,
    OP_LOOKUP,
    OP_FLUSH,
    OP_NONE
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [MAC_W-1:0]      mac;
    logic [VLAN_W-1:0]     vlan;
    logic [PORT_W-1:0]     port;
    logic [STAMP_W-1:0]    now;
  } req_t;

  // Front to back handoff
  typedef struct packed {
    logic valid;
    req_t req;
  } q_out_t;

  // One table entry as stored in RAM
  typedef struct packed {
    logic [MAC_W-1:0]   mac;
    logic [VLAN_W-1:0]  vlan;
    logic [PORT_W-1:0]  port;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_WRITE,
    BK_DONE
  } bk_state_t;

endpackage

// ===== hdl/mac_learning_table_top.sv =====
`timescale 1ns / 1ps

// Channel   Ports                        Content
// -------   --------------------------   ---------------------------------------
// request   in_tvalid/tready/tdata/tuser tuser opcode, tdata key, port, time
// result    out_tvalid/tready/tdata      tdata hit, found port, slot
//
// Each request makes one pass over the entry RAM in the back end, one read
// per cycle through its read port. Learn adds a write state (BK_WRITE); an
// unused opcode skips the pass.
// Reset (rst_n low, synchronous) empties the table and the request queue.
// A two-deep request queue keeps taking requests until it is full while the
// back end works or while a result waits in the output register.

module mac_learning_table_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [47:0] mac_addr, [59:48] vlan_id, [63:60] port_id, [95:64] now_time
  input  logic [mlt_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] opcode
  input  logic [mlt_pkg::OPC_W-1:0]      in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] hit, [4:1] found_port, [10:5] slot, [15:11] zero
  output logic [mlt_pkg::OUT_DATA_W-1:0] out_tdata
);

  mlt_pkg::q_out_t q_out;
  logic            q_pop;

  mlt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_out     (q_out),
    .q_pop     (q_pop)
  );

  mlt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_in       (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hdl/mlt_ram.sv =====
`timescale 1ns / 1ps

module mlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/mlt_front.sv =====
`timescale 1ns / 1ps

module mlt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mlt_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [mlt_pkg::OPC_W-1:0]     in_tuser,
  output mlt_pkg::q_out_t               q_out,
  input  logic                          q_pop
);

  mlt_pkg::req_t                q_mem_r [mlt_pkg::QDEPTH];
  logic [mlt_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [mlt_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [mlt_pkg::QCNT_W-1:0]   q_cnt_r, q_cnt_nxt;
  mlt_pkg::req_t                req_in;
  logic                         push;
  logic                         pop;

  // Decode the opcode and unpack the request fields
  always_comb begin
    case (in_tuser)
      mlt_pkg::OPC_LEARN:  req_in.kind = mlt_pkg::OP_LEARN;
      mlt_pkg::OPC_LOOKUP: req_in.kind = mlt_pkg::OP_LOOKUP;
      mlt_pkg::OPC_FLUSH:  req_in.kind = mlt_pkg::OP_FLUSH;
      default:             req_in.kind = mlt_pkg::OP_NONE;
    endcase
    req_in.mac  = in_tdata[mlt_pkg::MAC_W-1:0];
    req_in.vlan = in_tdata[mlt_pkg::MAC_W +: mlt_pkg::VLAN_W];
    req_in.port = in_tdata[mlt_pkg::MAC_W + mlt_pkg::VLAN_W +: mlt_pkg::PORT_W];
    req_in.now  = in_tdata[mlt_pkg::MAC_W + mlt_pkg::VLAN_W + mlt_pkg::PORT_W +:
                           mlt_pkg::STAMP_W];
  end

  assign in_tready = (q_cnt_r != mlt_pkg::QCNT_W'(mlt_pkg::QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_out.valid;

  assign q_out.valid = (q_cnt_r != '0);
  assign q_out.req   = q_mem_r[rd_ptr_r];

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + mlt_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + mlt_pkg::QPTR_W'(1) : rd_ptr_r;
    q_cnt_nxt  = q_cnt_r;
    if (push && !pop) begin
      q_cnt_nxt = q_cnt_r + mlt_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      q_cnt_nxt = q_cnt_r - mlt_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= req_in;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= mlt_pkg::QCNT_W'(mlt_pkg::QDEPTH))
    else $error("queue count above depth");

  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> q_cnt_r == $past(q_cnt_r) + mlt_pkg::QCNT_W'(1))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");
`endif

endmodule

// ===== hdl/mlt_back.sv =====
`timescale 1ns / 1ps

module mlt_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mlt_pkg::q_out_t                q_in,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mlt_pkg::OUT_DATA_W-1:0] out_tdata
);

  mlt_pkg::bk_state_t             state_r, state_nxt;
  mlt_pkg::req_t                  req_r, req_nxt;
  logic [mlt_pkg::CNT_W-1:0]      rd_cnt_r, rd_cnt_nxt;
  logic                           cmp_vld_r, cmp_vld_nxt;
  logic [mlt_pkg::IDX_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [mlt_pkg::ENTRIES-1:0]    valid_r, valid_nxt;
  logic                           match_found_r, match_found_nxt;
  logic [mlt_pkg::IDX_W-1:0]      match_idx_r, match_idx_nxt;
  logic [mlt_pkg::PORT_W-1:0]     match_port_r, match_port_nxt;
  logic                           empty_found_r, empty_found_nxt;
  logic [mlt_pkg::IDX_W-1:0]      empty_idx_r, empty_idx_nxt;
  logic                           oldest_set_r, oldest_set_nxt;
  logic [mlt_pkg::IDX_W-1:0]      oldest_idx_r, oldest_idx_nxt;
  logic [mlt_pkg::STAMP_W-1:0]    oldest_stamp_r, oldest_stamp_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [mlt_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                           ram_we;
  logic [mlt_pkg::IDX_W-1:0]      ram_raddr;
  logic [mlt_pkg::ENT_W-1:0]      ram_rdata;
  mlt_pkg::entry_t                rd_ent;
  mlt_pkg::entry_t                wr_ent;
  logic [mlt_pkg::IDX_W-1:0]      wr_idx;
  logic                           e_vld;
  logic                           key_eq;
  logic                           res_hit;
  logic [mlt_pkg::PORT_W-1:0]     res_port;
  logic [mlt_pkg::IDX_W-1:0]      res_idx;

  mlt_ram #(
    .WIDTH (mlt_pkg::ENT_W),
    .DEPTH (mlt_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (wr_ent),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent = ram_rdata;

  // Learn target: existing key, else first empty slot, else oldest stamp
  assign wr_idx = match_found_r ? match_idx_r :
                  empty_found_r ? empty_idx_r : oldest_idx_r;

  assign wr_ent.mac   = req_r.mac;
  assign wr_ent.vlan  = req_r.vlan;
  assign wr_ent.port  = req_r.port;
  assign wr_ent.stamp = req_r.now;

  assign e_vld  = valid_r[cmp_idx_r];
  assign key_eq = (rd_ent.mac == req_r.mac) && (rd_ent.vlan == req_r.vlan);

  // Result fields per operation
  always_comb begin
    res_hit  = 1'b0;
    res_port = '0;
    res_idx  = '0;
    case (req_r.kind)
      mlt_pkg::OP_LEARN: begin
        res_hit = match_found_r;
        res_idx = wr_idx;
      end
      mlt_pkg::OP_LOOKUP: begin
        res_hit  = match_found_r;
        res_port = match_found_r ? match_port_r : '0;
        res_idx  = match_found_r ? match_idx_r : '0;
      end
      default: begin
        res_hit = 1'b0;
      end
    endcase
  end

  // Sequencer: walk every entry (unused opcodes skip the walk), then write for learn, then post result
  always_comb begin
    state_nxt        = state_r;
    req_nxt          = req_r;
    rd_cnt_nxt       = rd_cnt_r;
    cmp_vld_nxt      = 1'b0;
    cmp_idx_nxt      = cmp_idx_r;
    valid_nxt        = valid_r;
    match_found_nxt  = match_found_r;
    match_idx_nxt    = match_idx_r;
    match_port_nxt   = match_port_r;
    empty_found_nxt  = empty_found_r;
    empty_idx_nxt    = empty_idx_r;
    oldest_set_nxt   = oldest_set_r;
    oldest_idx_nxt   = oldest_idx_r;
    oldest_stamp_nxt = oldest_stamp_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    q_pop            = 1'b0;
    ram_we           = 1'b0;
    ram_raddr        = rd_cnt_r[mlt_pkg::IDX_W-1:0];

    // drain output register
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // compare stage, one entry per cycle
    if (cmp_vld_r) begin
      if (e_vld && key_eq && !match_found_r) begin
        match_found_nxt = 1'b1;
        match_idx_nxt   = cmp_idx_r;
        match_port_nxt  = rd_ent.port;
      end
      if (!e_vld && !empty_found_r) begin
        empty_found_nxt = 1'b1;
        empty_idx_nxt   = cmp_idx_r;
      end
      if (e_vld && (!oldest_set_r || (rd_ent.stamp < oldest_stamp_r))) begin
        oldest_set_nxt   = 1'b1;
        oldest_idx_nxt   = cmp_idx_r;
        oldest_stamp_nxt = rd_ent.stamp;
      end
      if (req_r.kind == mlt_pkg::OP_FLUSH && e_vld && rd_ent.port == req_r.port) begin
        valid_nxt[cmp_idx_r] = 1'b0;
      end
    end

    case (state_r)
      mlt_pkg::BK_IDLE: begin
        if (q_in.valid) begin
          q_pop           = 1'b1;
          req_nxt         = q_in.req;
          rd_cnt_nxt      = '0;
          match_found_nxt = 1'b0;
          empty_found_nxt = 1'b0;
          oldest_set_nxt  = 1'b0;
          state_nxt       = (q_in.req.kind == mlt_pkg::OP_NONE) ?
                            mlt_pkg::BK_DONE : mlt_pkg::BK_SCAN;
        end
      end
      mlt_pkg::BK_SCAN: begin
        if (rd_cnt_r < mlt_pkg::CNT_W'(mlt_pkg::ENTRIES)) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_cnt_r[mlt_pkg::IDX_W-1:0];
          rd_cnt_nxt  = rd_cnt_r + mlt_pkg::CNT_W'(1);
        end else if (!cmp_vld_r) begin
          state_nxt = (req_r.kind == mlt_pkg::OP_LEARN) ?
                      mlt_pkg::BK_WRITE : mlt_pkg::BK_DONE;
        end
      end
      mlt_pkg::BK_WRITE: begin
        ram_we            = 1'b1;
        valid_nxt[wr_idx] = 1'b1;
        state_nxt         = mlt_pkg::BK_DONE;
      end
      mlt_pkg::BK_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(mlt_pkg::OUT_DATA_W - mlt_pkg::OUT_FIELD_W){1'b0}},
                           mlt_pkg::SLOT_W'(res_idx), res_port, res_hit};
          state_nxt     = mlt_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = mlt_pkg::BK_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlt_pkg::BK_IDLE;
      cmp_vld_r   <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scan bookkeeping
  always_ff @(posedge clk) begin
    req_r          <= req_nxt;
    rd_cnt_r       <= rd_cnt_nxt;
    cmp_idx_r      <= cmp_idx_nxt;
    match_found_r  <= match_found_nxt;
    match_idx_r    <= match_idx_nxt;
    match_port_r   <= match_port_nxt;
    empty_found_r  <= empty_found_nxt;
    empty_idx_r    <= empty_idx_nxt;
    oldest_set_r   <= oldest_set_nxt;
    oldest_idx_r   <= oldest_idx_nxt;
    oldest_stamp_r <= oldest_stamp_nxt;
    out_data_r     <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mlt_pkg::BK_IDLE) |-> !q_pop)
    else $error("request taken while busy");

  a_cmp_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (state_r == mlt_pkg::BK_SCAN))
    else $error("compare stage active outside scan");

  a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> valid_r[$past(wr_idx)])
    else $error("written entry not marked valid");

  a_write_learn: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (req_r.kind == mlt_pkg::OP_LEARN))
    else $error("table write outside learn");
`endif

endmodule
